FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the RTL of the CSV field parser.
// Each macro expects clk and rst_n to exist in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ECSV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ecsv assertion failed");

// Next-cycle implication, checked outside reset.
`define ECSV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ecsv assertion failed");

`endif

FILE: rtl/core/ecsv_pkg.sv
// ----------------------------------------------------------------------------
// ecsv_pkg
// Types and constants shared by the escaped CSV field parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ecsv_pkg;

  localparam int BYTE_W     = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE     = 8'd10;
  localparam logic [BYTE_W-1:0] SEPARATOR_RESET  = 8'd44;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET     = 8'd92;
  localparam logic [BYTE_W-1:0] NULL_MARK_RESET  = 8'd120;

  typedef enum logic [2:0] {
    PH_START      = 3'd0,
    PH_FIELD      = 3'd1,
    PH_ESC_START  = 3'd2,
    PH_ESC_FIELD  = 3'd3,
    PH_AFTER_NULL = 3'd4,
    PH_ERROR      = 3'd5,
    PH_DONE       = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    K_DATA      = 3'd0,
    K_FIELD_END = 3'd1,
    K_NULL_END  = 3'd2,
    K_ROW_END   = 3'd3,
    K_ERROR     = 3'd4,
    K_DONE      = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    E_EOL        = 2'd0,
    E_NULL_EXTRA = 2'd1,
    E_BAD_ESCAPE = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    REG_SEPARATOR   = 2'd0,
    REG_ESCAPE      = 2'd1,
    REG_NULL_MARKER = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] separator_char;
    logic [BYTE_W-1:0] escape_char;
    logic [BYTE_W-1:0] null_marker_char;
  } cfg_regs_t;

endpackage

`default_nettype wire

FILE: rtl/core/ecsv_if.sv
// ----------------------------------------------------------------------------
// ecsv_in_if / ecsv_out_if
// Valid/ready channels carrying raw input bytes and decoded results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ecsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface ecsv_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] value_byte;
  logic [1:0] error_code;

  modport source (output valid, output kind, output value_byte, output error_code,
                  input ready);
  modport sink   (input valid, input kind, input value_byte, input error_code,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ecsv_regs.sv
// ----------------------------------------------------------------------------
// ecsv_regs
// APB register bank holding the separator, escape and null marker bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecsv_regs (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [ecsv_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire  [ecsv_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ecsv_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output ecsv_pkg::cfg_regs_t                cfg
);
  import ecsv_pkg::*;

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_SEPARATOR:   cfg_nxt.separator_char   = pwdata[BYTE_W-1:0];
        REG_ESCAPE:      cfg_nxt.escape_char      = pwdata[BYTE_W-1:0];
        REG_NULL_MARKER: cfg_nxt.null_marker_char = pwdata[BYTE_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.separator_char   <= SEPARATOR_RESET;
      cfg_r.escape_char      <= ESCAPE_RESET;
      cfg_r.null_marker_char <= NULL_MARK_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_SEPARATOR:   prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, cfg_r.separator_char};
      REG_ESCAPE:      prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, cfg_r.escape_char};
      REG_NULL_MARKER: prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, cfg_r.null_marker_char};
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/escaped_csv_field_parser.sv
// ----------------------------------------------------------------------------
// escaped_csv_field_parser
// Decodes an escaped CSV byte stream into data bytes, field ends, null
// fields, row ends, errors and an end-of-stream marker.
//
//   channel   direction  handshake      beat contents
//   in_chan   sink       valid/ready    data_byte, end_of_input
//   out_chan  source     valid/ready    kind, value_byte, error_code
//   apb       slave      psel/penable   separator, escape, null marker
//
// One beat per cycle: each input beat is decoded in the cycle it is taken
// and its result, if any, lands in the output register at that edge.
// The output register is the only buffer, so input is taken whenever it is
// empty or being drained in the same cycle.
// rst_n is synchronous; it clears the phase, the line flag and out valid.
// After an error or stream done, input beats are still taken but dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module escaped_csv_field_parser (
  input  wire                              clk,
  input  wire                              rst_n,
  ecsv_in_if.sink                          in_chan,
  ecsv_out_if.source                       out_chan,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [ecsv_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire  [ecsv_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ecsv_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import ecsv_pkg::*;

  cfg_regs_t         cfg;
  phase_t            phase_r, phase_nxt;
  logic              line_r, line_nxt;
  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r;
  logic [BYTE_W-1:0] out_value_r;
  err_t              out_code_r;

  logic              in_acc;
  logic              res_valid;
  kind_t             res_kind;
  logic [BYTE_W-1:0] res_value;
  err_t              res_code;

  logic [BYTE_W-1:0] b;
  logic              eoi, is_nl, is_sep, is_esc, is_null;

  ecsv_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_chan.ready = ~out_valid_r | out_chan.ready;
  assign in_acc        = in_chan.valid & in_chan.ready;

  assign b       = in_chan.data_byte;
  assign eoi     = in_chan.end_of_input;
  assign is_nl   = (b == NEWLINE_BYTE);
  assign is_sep  = (b == cfg.separator_char);
  assign is_esc  = (b == cfg.escape_char);
  assign is_null = (b == cfg.null_marker_char);

  // Next phase and line flag.
  always_comb begin
    phase_nxt = phase_r;
    line_nxt  = line_r;
    if (in_acc) begin
      if (eoi) begin
        case (phase_r)
          PH_START: begin
            if (line_r) line_nxt = 1'b0;
            else        phase_nxt = PH_DONE;
          end
          PH_FIELD, PH_ESC_START, PH_ESC_FIELD, PH_AFTER_NULL: phase_nxt = PH_ERROR;
          default: phase_nxt = phase_r;
        endcase
      end else begin
        case (phase_r)
          PH_START, PH_FIELD: begin
            if (is_nl) begin
              if (phase_r == PH_FIELD) phase_nxt = PH_ERROR;
              else                     line_nxt  = 1'b0;
            end else if (is_sep) begin
              phase_nxt = PH_START;
              line_nxt  = 1'b1;
            end else if (is_esc) begin
              phase_nxt = (phase_r == PH_START) ? PH_ESC_START : PH_ESC_FIELD;
            end else begin
              phase_nxt = PH_FIELD;
            end
          end
          PH_ESC_START, PH_ESC_FIELD: begin
            if (is_nl) begin
              phase_nxt = PH_ERROR;
            end else if (is_esc || (!is_null && is_sep)) begin
              phase_nxt = PH_FIELD;
            end else if (is_null) begin
              phase_nxt = (phase_r == PH_ESC_FIELD) ? PH_ERROR : PH_AFTER_NULL;
            end else begin
              phase_nxt = PH_ERROR;
            end
          end
          PH_AFTER_NULL: begin
            if (!is_nl && is_sep) begin
              phase_nxt = PH_START;
              line_nxt  = 1'b1;
            end else begin
              phase_nxt = PH_ERROR;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // Result of the current beat, if it makes one.
  always_comb begin
    res_valid = 1'b0;
    res_kind  = K_DATA;
    res_value = '0;
    res_code  = E_EOL;
    if (eoi) begin
      case (phase_r)
        PH_START: begin
          res_valid = 1'b1;
          res_kind  = line_r ? K_ROW_END : K_DONE;
        end
        PH_FIELD: begin
          res_valid = 1'b1;
          res_kind  = K_ERROR;
          res_code  = E_EOL;
        end
        PH_AFTER_NULL: begin
          res_valid = 1'b1;
          res_kind  = K_ERROR;
          res_code  = E_NULL_EXTRA;
        end
        PH_ESC_START, PH_ESC_FIELD: begin
          res_valid = 1'b1;
          res_kind  = K_ERROR;
          res_code  = E_BAD_ESCAPE;
        end
        default: res_valid = 1'b0;
      endcase
    end else begin
      case (phase_r)
        PH_START, PH_FIELD: begin
          if (is_nl) begin
            res_valid = 1'b1;
            res_kind  = (phase_r == PH_FIELD) ? K_ERROR : K_ROW_END;
            res_code  = E_EOL;
          end else if (is_sep) begin
            res_valid = 1'b1;
            res_kind  = K_FIELD_END;
          end else if (!is_esc) begin
            res_valid = 1'b1;
            res_kind  = K_DATA;
            res_value = b;
          end
        end
        PH_ESC_START, PH_ESC_FIELD: begin
          if (is_nl) begin
            res_valid = 1'b1;
            res_kind  = K_ERROR;
            res_code  = E_BAD_ESCAPE;
          end else if (is_esc || (!is_null && is_sep)) begin
            res_valid = 1'b1;
            res_kind  = K_DATA;
            res_value = b;
          end else if (is_null) begin
            // A null marker is only legal as the first thing in a field.
            if (phase_r == PH_ESC_FIELD) begin
              res_valid = 1'b1;
              res_kind  = K_ERROR;
              res_code  = E_NULL_EXTRA;
            end
          end else begin
            res_valid = 1'b1;
            res_kind  = K_ERROR;
            res_code  = E_BAD_ESCAPE;
          end
        end
        PH_AFTER_NULL: begin
          res_valid = 1'b1;
          if (!is_nl && is_sep) begin
            res_kind = K_NULL_END;
          end else begin
            res_kind = K_ERROR;
            res_code = E_NULL_EXTRA;
          end
        end
        default: res_valid = 1'b0;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc && res_valid)  out_valid_nxt = 1'b1;
    else if (out_chan.ready)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      line_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      line_r      <= line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_kind_r  <= res_kind;
      out_value_r <= res_value;
      out_code_r  <= res_code;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.kind       = out_kind_r;
  assign out_chan.value_byte = out_value_r;
  assign out_chan.error_code = out_code_r;

  `ECSV_ASSERT_NEXT(a_error_sticky, phase_r == PH_ERROR, phase_r == PH_ERROR)
  `ECSV_ASSERT_NEXT(a_error_enters_phase, in_acc && res_valid && res_kind == K_ERROR,
                    phase_r == PH_ERROR)
  `ECSV_ASSERT_NOW(a_silent_when_finished,
                   in_acc && (phase_r == PH_ERROR || phase_r == PH_DONE), !res_valid)
  `ECSV_ASSERT_NOW(a_value_only_for_data, out_valid_r && out_kind_r != K_DATA,
                   out_value_r == '0)

endmodule

`default_nettype wire
